// File: rtl/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion converter.
package rmq_pkg;

  localparam int FRAC_BITS = 14;

  localparam int               LIMIT_W   = 15;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 15'd164;

  // digit steps per pipeline stage
  localparam int ISQ_STEPS = 2;
  localparam int DIV_STEPS = 2;

  // datapath widths
  localparam int RAD_W     = 30;  // |4*w^2| and half-turn radicands
  localparam int ROOT_W    = 15;
  localparam int DIF_W     = 17;
  localparam int VDEN_W    = 17;  // 4*w
  localparam int VQ_W      = 29;  // vector part before renormalizing
  localparam int SQV_W     = 58;
  localparam int SQW_W     = 30;
  localparam int PSUM_W    = 59;
  localparam int MAG_RAD_W = 60;
  localparam int MAG_W     = 30;
  localparam int FQ_W      = 15;

  localparam int LATENCY = 1 + (ROOT_W + ISQ_STEPS - 1) / ISQ_STEPS + 1
                         + (VQ_W + DIV_STEPS - 1) / DIV_STEPS + 4
                         + (MAG_W + ISQ_STEPS - 1) / ISQ_STEPS
                         + (FQ_W + DIV_STEPS - 1) / DIV_STEPS + 1;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               half_turn_path;
  } quat_t;

endpackage

// File: rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix to unit quaternion converter, fully pipelined.
//
// Usage:
//   Drive a row-major Q1.14 matrix on mat_i and pulse start. busy stays low,
//   so a matrix is taken on every cycle that start is high.
//   Each matrix gives one quaternion beat on quat_o, marked by done_o for
//   one cycle. Throughput is one matrix per cycle. The latency is set by
//   the digit-serial square root and divider stages (two result bits per
//   stage): w root 8, vector divide 15, magnitude root 15, renormalize
//   divide 8, plus 7 stages of prep, squaring, summing and output.
//   The result side cannot hold beats off; a beat shows exactly once.
//   cfg_data_i writes the half-turn threshold on q0 when cfg_valid_i is
//   high; cfg_ready_o is always high. Write it only with the pipe empty.
//   Reset empties the pipeline and sets the threshold to 164 (about 0.01).
module rotation_matrix_to_quaternion (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  rmq_pkg::mat_t               mat_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rmq_pkg::LIMIT_W-1:0] cfg_data_i,
  output logic                        done_o,
  output rmq_pkg::quat_t              quat_o
);

  import rmq_pkg::*;

  localparam logic signed [18:0] ONE_S = 19'(1 << FRAC_BITS);

  function automatic logic [17:0] abs19(input logic signed [18:0] v);
    logic signed [18:0] n;
    n = -v;
    return v[18] ? 18'(n) : 18'(v);
  endfunction

  function automatic logic [15:0] abs17(input logic signed [16:0] v);
    logic signed [16:0] n;
    n = -v;
    return v[16] ? 16'(n) : 16'(v);
  endfunction

  // -------- threshold register
  logic [LIMIT_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  // -------- stage A: trace, half-turn radicands, differences, sign rules
  logic                    a_vld_q;
  logic [RAD_W-1:0]        a_rad_q [4];
  logic signed [DIF_W-1:0] a_dif_q [3];
  logic [2:0]              a_hneg_q;

  logic [RAD_W-1:0]        a_rad_d [4];
  logic signed [DIF_W-1:0] a_dif_d [3];
  logic [2:0]              a_hneg_d;

  always_comb begin : p_prep
    logic signed [18:0]      e00, e11, e22;
    logic signed [18:0]      t4, hx, hy, hz;
    logic signed [DIF_W-1:0] s01, s12;
    e00 = 19'(mat_i.m00);
    e11 = 19'(mat_i.m11);
    e22 = 19'(mat_i.m22);
    t4  = ONE_S + e00 + e11 + e22;
    hx  = ONE_S + e00 - e11 - e22;
    hy  = ONE_S - e00 + e11 - e22;
    hz  = ONE_S - e00 - e11 + e22;
    a_rad_d[0] = RAD_W'(abs19(t4)) << (FRAC_BITS - 2);
    a_rad_d[1] = RAD_W'(abs19(hx)) << (FRAC_BITS - 2);
    a_rad_d[2] = RAD_W'(abs19(hy)) << (FRAC_BITS - 2);
    a_rad_d[3] = RAD_W'(abs19(hz)) << (FRAC_BITS - 2);
    a_dif_d[0] = DIF_W'(mat_i.m12) - DIF_W'(mat_i.m21);
    a_dif_d[1] = DIF_W'(mat_i.m20) - DIF_W'(mat_i.m02);
    a_dif_d[2] = DIF_W'(mat_i.m01) - DIF_W'(mat_i.m10);
    s01 = DIF_W'(mat_i.m01) + DIF_W'(mat_i.m10);
    s12 = DIF_W'(mat_i.m12) + DIF_W'(mat_i.m21);
    // half-turn signs: y follows s01, z follows the s01/s12 mismatch, all flip on m12<m21
    a_hneg_d[0] = a_dif_d[0][DIF_W-1];
    a_hneg_d[1] = s01[DIF_W-1] ^ a_hneg_d[0];
    a_hneg_d[2] = ((s01[DIF_W-1] && !s12[DIF_W-1] && (s12 != '0))
                || (!s01[DIF_W-1] && (s01 != '0) && s12[DIF_W-1])) ^ a_hneg_d[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    a_rad_q  <= a_rad_d;
    a_dif_q  <= a_dif_d;
    a_hneg_q <= a_hneg_d;
  end

  // -------- roots: w and the three half-turn magnitudes
  logic                    r_vld [4];
  logic [ROOT_W-1:0]       r_root [4];
  logic [2:0]              r_hneg;
  logic signed [DIF_W-1:0] r_dif [3];

  rmq_isqrt #(.IN_W(RAD_W), .SB_W(3), .STEPS(ISQ_STEPS)) u_sqrt_w (
    .clk_i, .rst_ni,
    .valid_i (a_vld_q),
    .rad_i   (a_rad_q[0]),
    .sb_i    (a_hneg_q),
    .valid_o (r_vld[0]),
    .root_o  (r_root[0]),
    .sb_o    (r_hneg)
  );

  for (genvar i = 1; i < 4; i++) begin : g_hsqrt
    logic [DIF_W-1:0] dif_u;
    rmq_isqrt #(.IN_W(RAD_W), .SB_W(DIF_W), .STEPS(ISQ_STEPS)) u_sqrt_h (
      .clk_i, .rst_ni,
      .valid_i (a_vld_q),
      .rad_i   (a_rad_q[i]),
      .sb_i    (a_dif_q[i-1]),
      .valid_o (r_vld[i]),
      .root_o  (r_root[i]),
      .sb_o    (dif_u)
    );
    assign r_dif[i-1] = dif_u;
  end

  // -------- stage B: path select, divider operands
  logic                    b_vld_q, b_half_q;
  logic [2:0]              b_neg_q;
  logic [VDEN_W+VQ_W-1:0]  b_num_q [3];
  logic [VDEN_W-1:0]       b_den_q;
  logic [ROOT_W-1:0]       b_h_q [3];
  logic [ROOT_W-1:0]       b_w_q;
  logic                    b_half_d;

  assign b_half_d = !(r_root[0] > limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= r_vld[0] && r_vld[1] && r_vld[2] && r_vld[3];
    end
  end

  always_ff @(posedge clk_i) begin
    b_half_q <= b_half_d;
    b_den_q  <= {r_root[0], 2'b00};
    b_w_q    <= r_root[0];
    for (int i = 0; i < 3; i++) begin
      b_num_q[i] <= (VDEN_W + VQ_W)'(abs17(r_dif[i])) << FRAC_BITS;
      b_neg_q[i] <= b_half_d ? r_hneg[i] : r_dif[i][DIF_W-1];
      b_h_q[i]   <= r_root[i+1];
    end
  end

  // -------- vector part divides by 4*w
  logic              v_vld [3];
  logic [VQ_W-1:0]   v_quot [3];
  logic              v_half;
  logic [ROOT_W-1:0] v_w;
  logic [2:0]        v_neg;
  logic [ROOT_W-1:0] v_h [3];

  rmq_div #(.DEN_W(VDEN_W), .Q_W(VQ_W), .SB_W(2 * ROOT_W + 2), .STEPS(DIV_STEPS))
  u_div_x (
    .clk_i, .rst_ni,
    .valid_i (b_vld_q),
    .num_i   (b_num_q[0]),
    .den_i   (b_den_q),
    .sb_i    ({b_half_q, b_w_q, b_neg_q[0], b_h_q[0]}),
    .valid_o (v_vld[0]),
    .quot_o  (v_quot[0]),
    .sb_o    ({v_half, v_w, v_neg[0], v_h[0]})
  );

  for (genvar i = 1; i < 3; i++) begin : g_vdiv
    rmq_div #(.DEN_W(VDEN_W), .Q_W(VQ_W), .SB_W(ROOT_W + 1), .STEPS(DIV_STEPS)) u_div_v (
      .clk_i, .rst_ni,
      .valid_i (b_vld_q),
      .num_i   (b_num_q[i]),
      .den_i   (b_den_q),
      .sb_i    ({b_neg_q[i], b_h_q[i]}),
      .valid_o (v_vld[i]),
      .quot_o  (v_quot[i]),
      .sb_o    ({v_neg[i], v_h[i]})
    );
  end

  // -------- stage C: pick magnitudes
  logic              c_vld_q, c_half_q;
  logic [2:0]        c_neg_q;
  logic [ROOT_W-1:0] c_w_q;
  logic [VQ_W-1:0]   c_v_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= v_vld[0] && v_vld[1] && v_vld[2];
    end
  end

  always_ff @(posedge clk_i) begin
    c_half_q <= v_half;
    c_neg_q  <= v_neg;
    c_w_q    <= v_w;
    for (int i = 0; i < 3; i++) begin
      c_v_q[i] <= v_half ? VQ_W'(v_h[i]) : v_quot[i];
    end
  end

  // -------- stage D: squares
  logic              d_vld_q, d_half_q;
  logic [2:0]        d_neg_q;
  logic [ROOT_W-1:0] d_w_q;
  logic [VQ_W-1:0]   d_v_q [3];
  logic [SQW_W-1:0]  d_sqw_q;
  logic [SQV_W-1:0]  d_sqv_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_half_q <= c_half_q;
    d_neg_q  <= c_neg_q;
    d_w_q    <= c_w_q;
    d_v_q    <= c_v_q;
    d_sqw_q  <= SQW_W'(c_w_q) * SQW_W'(c_w_q);
    for (int i = 0; i < 3; i++) begin
      d_sqv_q[i] <= SQV_W'(c_v_q[i]) * SQV_W'(c_v_q[i]);
    end
  end

  // -------- stage E: pair sums
  logic              e_vld_q, e_half_q;
  logic [2:0]        e_neg_q;
  logic [ROOT_W-1:0] e_w_q;
  logic [VQ_W-1:0]   e_v_q [3];
  logic [PSUM_W-1:0] e_sa_q, e_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_half_q <= d_half_q;
    e_neg_q  <= d_neg_q;
    e_w_q    <= d_w_q;
    e_v_q    <= d_v_q;
    e_sa_q   <= PSUM_W'(d_sqw_q) + PSUM_W'(d_sqv_q[0]);
    e_sb_q   <= PSUM_W'(d_sqv_q[1]) + PSUM_W'(d_sqv_q[2]);
  end

  // -------- stage F: sum of squares
  logic                 f_vld_q, f_half_q;
  logic [2:0]           f_neg_q;
  logic [ROOT_W-1:0]    f_w_q;
  logic [VQ_W-1:0]      f_v_q [3];
  logic [MAG_RAD_W-1:0] f_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f_half_q <= e_half_q;
    f_neg_q  <= e_neg_q;
    f_w_q    <= e_w_q;
    f_v_q    <= e_v_q;
    f_sum_q  <= MAG_RAD_W'(e_sa_q) + MAG_RAD_W'(e_sb_q);
  end

  // -------- magnitude root
  localparam int MSB_W = 1 + 3 + ROOT_W + 3 * VQ_W;

  logic              m_vld;
  logic [MAG_W-1:0]  m_mag;
  logic              m_half;
  logic [2:0]        m_neg;
  logic [ROOT_W-1:0] m_w;
  logic [VQ_W-1:0]   m_v [3];
  logic              m_zero;

  rmq_isqrt #(.IN_W(MAG_RAD_W), .SB_W(MSB_W), .STEPS(ISQ_STEPS)) u_sqrt_mag (
    .clk_i, .rst_ni,
    .valid_i (f_vld_q),
    .rad_i   (f_sum_q),
    .sb_i    ({f_half_q, f_neg_q, f_w_q, f_v_q[0], f_v_q[1], f_v_q[2]}),
    .valid_o (m_vld),
    .root_o  (m_mag),
    .sb_o    ({m_half, m_neg, m_w, m_v[0], m_v[1], m_v[2]})
  );

  assign m_zero = (m_mag == '0);

  // -------- renormalize: component * ONE / mag, never above ONE since mag >= |c|
  localparam int FNUM_W = MAG_W + FQ_W;

  logic            n_vld [4];
  logic [FQ_W-1:0] n_quot [4];
  logic            n_half, n_zero;
  logic [2:0]      n_neg;

  rmq_div #(.DEN_W(MAG_W), .Q_W(FQ_W), .SB_W(2), .STEPS(DIV_STEPS)) u_div_w (
    .clk_i, .rst_ni,
    .valid_i (m_vld),
    .num_i   (FNUM_W'(m_w) << FRAC_BITS),
    .den_i   (m_mag),
    .sb_i    ({m_half, m_zero}),
    .valid_o (n_vld[0]),
    .quot_o  (n_quot[0]),
    .sb_o    ({n_half, n_zero})
  );

  for (genvar i = 0; i < 3; i++) begin : g_ndiv
    rmq_div #(.DEN_W(MAG_W), .Q_W(FQ_W), .SB_W(1), .STEPS(DIV_STEPS)) u_div_n (
      .clk_i, .rst_ni,
      .valid_i (m_vld),
      .num_i   (FNUM_W'(m_v[i]) << FRAC_BITS),
      .den_i   (m_mag),
      .sb_i    (m_neg[i]),
      .valid_o (n_vld[i+1]),
      .quot_o  (n_quot[i+1]),
      .sb_o    (n_neg[i])
    );
  end

  // -------- output register
  logic  done_q;
  quat_t quat_q;
  quat_t quat_d;

  always_comb begin : p_out
    logic signed [15:0] mg [3];
    for (int i = 0; i < 3; i++) begin
      mg[i] = 16'(n_quot[i+1]);
      if (n_neg[i]) begin
        mg[i] = -mg[i];
      end
    end
    quat_d.quat_w         = n_zero ? '0 : 16'(n_quot[0]);
    quat_d.quat_x         = n_zero ? '0 : mg[0];
    quat_d.quat_y         = n_zero ? '0 : mg[1];
    quat_d.quat_z         = n_zero ? '0 : mg[2];
    quat_d.half_turn_path = n_half;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= n_vld[0] && n_vld[1] && n_vld[2] && n_vld[3];
    end
  end

  always_ff @(posedge clk_i) begin
    quat_q <= quat_d;
  end

  assign done_o = done_q;
  assign quat_o = quat_q;

endmodule

// File: rtl/rmq_isqrt.sv
// Pipelined floor integer square root, STEPS result bits per stage.
module rmq_isqrt #(
  parameter int IN_W  = 30,
  parameter int SB_W  = 1,
  parameter int STEPS = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [IN_W-1:0]   rad_i,
  input  logic [SB_W-1:0]   sb_i,
  output logic              valid_o,
  output logic [IN_W/2-1:0] root_o,
  output logic [SB_W-1:0]   sb_o
);

  localparam int R_W  = IN_W / 2;
  localparam int NSTG = (R_W + STEPS - 1) / STEPS;

  logic            vld_q  [NSTG];
  logic [R_W+1:0]  rem_q  [NSTG];
  logic [R_W-1:0]  root_q [NSTG];
  logic [IN_W-1:0] rad_q  [NSTG];
  logic [SB_W-1:0] sb_q   [NSTG];

  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    logic            vld_s;
    logic [R_W+1:0]  rem_s, rem_d;
    logic [R_W-1:0]  root_s, root_d;
    logic [IN_W-1:0] rad_s, rad_d;
    logic [SB_W-1:0] sb_s;

    if (g == 0) begin : g_first
      assign vld_s  = valid_i;
      assign rem_s  = '0;
      assign root_s = '0;
      assign rad_s  = rad_i;
      assign sb_s   = sb_i;
    end else begin : g_next
      assign vld_s  = vld_q[g-1];
      assign rem_s  = rem_q[g-1];
      assign root_s = root_q[g-1];
      assign rad_s  = rad_q[g-1];
      assign sb_s   = sb_q[g-1];
    end

    always_comb begin : p_step
      logic [R_W+1:0] sh;
      logic [R_W+1:0] trl;
      sh     = '0;
      trl    = '0;
      rem_d  = rem_s;
      root_d = root_s;
      rad_d  = rad_s;
      for (int k = 0; k < STEPS; k++) begin
        if (g * STEPS + k < R_W) begin
          // remainder stays below 2^R_W before the shift
          sh  = {rem_d[R_W-1:0], rad_d[IN_W-1 -: 2]};
          trl = {root_d, 2'b01};
          if (sh >= trl) begin
            rem_d  = sh - trl;
            root_d = {root_d[R_W-2:0], 1'b1};
          end else begin
            rem_d  = sh;
            root_d = {root_d[R_W-2:0], 1'b0};
          end
          rad_d = rad_d << 2;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g]  <= rem_d;
      root_q[g] <= root_d;
      rad_q[g]  <= rad_d;
      sb_q[g]   <= sb_s;
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign root_o  = root_q[NSTG-1];
  assign sb_o    = sb_q[NSTG-1];

endmodule

// File: rtl/rmq_div.sv
// Pipelined restoring divider; numerator must be below den * 2^Q_W.
module rmq_div #(
  parameter int DEN_W = 17,
  parameter int Q_W   = 29,
  parameter int SB_W  = 1,
  parameter int STEPS = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [DEN_W+Q_W-1:0]  num_i,
  input  logic [DEN_W-1:0]      den_i,
  input  logic [SB_W-1:0]       sb_i,
  output logic                  valid_o,
  output logic [Q_W-1:0]        quot_o,
  output logic [SB_W-1:0]       sb_o
);

  localparam int NSTG = (Q_W + STEPS - 1) / STEPS;

  logic             vld_q [NSTG];
  logic [DEN_W-1:0] rem_q [NSTG];
  logic [Q_W-1:0]   nq_q  [NSTG];
  logic [DEN_W-1:0] den_q [NSTG];
  logic [SB_W-1:0]  sb_q  [NSTG];

  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    logic             vld_s;
    logic [DEN_W-1:0] rem_s, rem_d;
    logic [Q_W-1:0]   nq_s, nq_d;
    logic [DEN_W-1:0] den_s;
    logic [SB_W-1:0]  sb_s;

    if (g == 0) begin : g_first
      assign vld_s = valid_i;
      assign rem_s = num_i[DEN_W+Q_W-1:Q_W];
      assign nq_s  = num_i[Q_W-1:0];
      assign den_s = den_i;
      assign sb_s  = sb_i;
    end else begin : g_next
      assign vld_s = vld_q[g-1];
      assign rem_s = rem_q[g-1];
      assign nq_s  = nq_q[g-1];
      assign den_s = den_q[g-1];
      assign sb_s  = sb_q[g-1];
    end

    // nq shifts numerator bits out at the top and quotient bits in at the bottom
    always_comb begin : p_step
      logic [DEN_W:0] sh;
      logic [DEN_W:0] dif;
      sh    = '0;
      dif   = '0;
      rem_d = rem_s;
      nq_d  = nq_s;
      for (int k = 0; k < STEPS; k++) begin
        if (g * STEPS + k < Q_W) begin
          sh = {rem_d, nq_d[Q_W-1]};
          if (sh >= {1'b0, den_s}) begin
            dif   = sh - {1'b0, den_s};
            rem_d = dif[DEN_W-1:0];
            nq_d  = {nq_d[Q_W-2:0], 1'b1};
          end else begin
            rem_d = sh[DEN_W-1:0];
            nq_d  = {nq_d[Q_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g] <= rem_d;
      nq_q[g]  <= nq_d;
      den_q[g] <= den_s;
      sb_q[g]  <= sb_s;
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign quot_o  = nq_q[NSTG-1];
  assign sb_o    = sb_q[NSTG-1];

endmodule

// File: rtl/rmq_checker.sv
// Port-level checks for the rotation matrix to quaternion converter.
module rmq_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input rmq_pkg::quat_t quat_o
);

  import rmq_pkg::*;

  localparam logic signed [15:0] ONE_Q = 16'(1 << FRAC_BITS);

  // every result beat traces back to a start beat a fixed latency earlier
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result beat without matching start beat");

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

  a_w_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (quat_o.quat_w >= 16'sd0 && quat_o.quat_w <= ONE_Q))
    else $error("scalar part out of range");

  a_v_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (quat_o.quat_x >= -ONE_Q && quat_o.quat_x <= ONE_Q
             && quat_o.quat_y >= -ONE_Q && quat_o.quat_y <= ONE_Q
             && quat_o.quat_z >= -ONE_Q && quat_o.quat_z <= ONE_Q))
    else $error("vector part out of range");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .quat_o (quat_o)
);

// File: verif/rotation_matrix_to_quaternion_test.sv
// Self-checking testbench for the rotation matrix to quaternion converter.
module rotation_matrix_to_quaternion_test;
  import rmq_pkg::*;

  localparam int ONE       = 1 << FRAC_BITS;
  localparam int DRAIN     = LATENCY + 20;
  localparam int STALL_MAX = 2000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  mat_t             mat_i = '0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [LIMIT_W-1:0] cfg_data_i = '0;
  logic             done_o;
  quat_t            quat_o;

  rotation_matrix_to_quaternion dut (.*);

  always #2 clk_i = ~clk_i;

  mat_t  pending_mats[$];
  quat_t expected_quats[$];
  logic [LIMIT_W-1:0] half_turn_limit;
  int    failures = 0;
  int    quiet_cycles = 0;
  int    gap_left = 0;
  bit    feed_enable = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  // signed quotient (|num| << FRAC_BITS) / den, truncated toward zero
  function automatic longint scaled_div(longint num, longint den);
    longint q;
    q = longint'((mag64(num) << FRAC_BITS) / den);
    return num < 0 ? -q : q;
  endfunction

  function automatic logic [15:0] renorm(longint c, longint unsigned m);
    longint q;
    q = scaled_div(c, longint'(m));
    if (q > ONE) q = ONE;
    if (q < -ONE) q = -ONE;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic longint clamp_vec(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483647) return -64'sd2147483647;
    return v;
  endfunction

  function automatic quat_t convert_matrix(mat_t m, logic [LIMIT_W-1:0] lim);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
    longint t4, w, x, y, z, s01, s12, d12;
    longint unsigned mg;
    quat_t q;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    t4 = ONE + a00 + a11 + a22;
    w = int_sqrt(mag64(t4) << (FRAC_BITS - 2));
    q.half_turn_path = !(w > lim);
    d12 = a12 - a21;
    if (!q.half_turn_path) begin
      x = scaled_div(d12, 4 * w);
      y = scaled_div(a20 - a02, 4 * w);
      z = scaled_div(a01 - a10, 4 * w);
    end else begin
      x = int_sqrt(mag64(2 * (ONE + a00) - t4) << (FRAC_BITS - 2));
      y = int_sqrt(mag64(2 * (ONE + a11) - t4) << (FRAC_BITS - 2));
      z = int_sqrt(mag64(2 * (ONE + a22) - t4) << (FRAC_BITS - 2));
      s01 = a01 + a10;
      s12 = a12 + a21;
      if (s01 < 0) begin
        y = -y;
        if (s12 > 0) z = -z;
      end else if (s01 > 0 && s12 < 0) begin
        z = -z;
      end
      if (d12 < 0) begin
        x = -x; y = -y; z = -z;
      end
    end
    x = clamp_vec(x); y = clamp_vec(y); z = clamp_vec(z);
    mg = int_sqrt(mag64(w) * mag64(w) + mag64(x) * mag64(x)
                  + mag64(y) * mag64(y) + mag64(z) * mag64(z));
    if (mg == 0) begin
      q.quat_w = '0; q.quat_x = '0; q.quat_y = '0; q.quat_z = '0;
    end else begin
      q.quat_w = renorm(w, mg);
      q.quat_x = renorm(x, mg);
      q.quat_y = renorm(y, mg);
      q.quat_z = renorm(z, mg);
    end
    return q;
  endfunction

  function automatic logic [15:0] rand_entry();
    case ($urandom_range(0, 9))
      0: return 16'(-16384);
      1: return 16'(16384);
      2: return 16'($urandom());
      3: return 16'($urandom_range(0, 400)) - 16'd200;
      default: return 16'($urandom_range(0, 32768)) - 16'd16384;
    endcase
  endfunction

  // rotation-like matrix: mostly real axis-angle, sometimes noise
  function automatic mat_t rand_matrix();
    mat_t m;
    real ax, ay, az, n, ang, c, s, t;
    if ($urandom_range(0, 9) < 3) begin
      m = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
           rand_entry(), rand_entry(), rand_entry(), rand_entry()};
      return m;
    end
    ax = real'($urandom_range(0, 2000)) - 1000.0;
    ay = real'($urandom_range(0, 2000)) - 1000.0;
    az = real'($urandom_range(0, 2000)) - 1000.0;
    n = $sqrt(ax * ax + ay * ay + az * az) + 1e-9;
    ax /= n; ay /= n; az /= n;
    if ($urandom_range(0, 3) == 0) ang = 3.14159265 - real'($urandom_range(0, 300)) / 1000.0;
    else ang = real'($urandom_range(0, 6283)) / 1000.0;
    c = $cos(ang); s = $sin(ang); t = 1.0 - c;
    m.m00 = $rtoi(16384.0 * (t * ax * ax + c));
    m.m01 = $rtoi(16384.0 * (t * ax * ay - s * az));
    m.m02 = $rtoi(16384.0 * (t * ax * az + s * ay));
    m.m10 = $rtoi(16384.0 * (t * ax * ay + s * az));
    m.m11 = $rtoi(16384.0 * (t * ay * ay + c));
    m.m12 = $rtoi(16384.0 * (t * ay * az - s * ax));
    m.m20 = $rtoi(16384.0 * (t * ax * az - s * ay));
    m.m21 = $rtoi(16384.0 * (t * ay * az + s * ax));
    m.m22 = $rtoi(16384.0 * (t * az * az + c));
    return m;
  endfunction

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    half_turn_limit = v;
  endtask

  task automatic run_phase(int count, bit directed);
    mat_t m;
    feed_enable = 1'b0;
    if (directed) begin
      m = '0; pending_mats.push_back(m);
      m = '1; pending_mats.push_back(m);
      m = {9{16'sd16384}}; pending_mats.push_back(m);
      m = {9{-16'sd16384}}; pending_mats.push_back(m);
      m = {9{16'h7fff}}; pending_mats.push_back(m);
      m = {9{16'h8000}}; pending_mats.push_back(m);
      // identity, half turns about each axis, zero trace sum
      m = '0; m.m00 = 16384; m.m11 = 16384; m.m22 = 16384; pending_mats.push_back(m);
      m = '0; m.m00 = 16384; m.m11 = -16384; m.m22 = -16384; pending_mats.push_back(m);
      m = '0; m.m00 = -16384; m.m11 = 16384; m.m22 = -16384; pending_mats.push_back(m);
      m = '0; m.m00 = -16384; m.m11 = -16384; m.m22 = 16384; pending_mats.push_back(m);
      m = '0; m.m00 = -16384; pending_mats.push_back(m);
      // half turn sign branches
      m = '0; m.m00 = -16384; m.m11 = -16384; m.m22 = 16384 - 16384;
      m.m01 = -300; m.m10 = -200; m.m12 = 400; m.m21 = 100; pending_mats.push_back(m);
      m.m01 = 300; m.m12 = -400; m.m21 = -100; pending_mats.push_back(m);
      m.m12 = -100; m.m21 = 200; pending_mats.push_back(m);
      // large off-diagonal with tiny w
      m = '0; m.m00 = 16384; m.m11 = -16384; m.m22 = -16383; m.m12 = 16384;
      m.m21 = -16384; m.m20 = 16384; m.m02 = -16384; m.m01 = 16384; m.m10 = -16384;
      pending_mats.push_back(m);
      for (int i = 0; i < 8; i++) pending_mats.push_back(rand_matrix());
    end
    for (int i = 0; i < count; i++) pending_mats.push_back(rand_matrix());
    feed_enable = 1'b1;
    wait (pending_mats.size() == 0 && expected_quats.size() == 0);
    repeat (5) @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      // accepted beat leaves the queue, so the head is always the next one to drive
      if (start && !busy) begin
        expected_quats.push_back(convert_matrix(mat_i, half_turn_limit));
        void'(pending_mats.pop_front());
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (feed_enable && pending_mats.size() > 0) begin
        mat_i <= pending_mats[0];
        start <= 1'b1;
        if ($urandom_range(0, 9) == 0)
          gap_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 80)
                                                   : $urandom_range(1, 3);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_quats.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $time, quat_o);
        failures++;
      end else begin
        quat_t e;
        e = expected_quats.pop_front();
        if (e.quat_w !== quat_o.quat_w || e.quat_x !== quat_o.quat_x ||
            e.quat_y !== quat_o.quat_y || e.quat_z !== quat_o.quat_z ||
            e.half_turn_path !== quat_o.half_turn_path) begin
          $display("%0t: mismatch, expected %h actual %h", $time, e, quat_o);
          failures++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || cfg_valid_i) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_MAX) begin
      $display("rotation_matrix_to_quaternion_test failed");
      $finish;
    end
  end

  initial begin
    half_turn_limit = LIMIT_RST;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_phase(400, 1'b1);
    write_limit('0);
    run_phase(200, 1'b0);
    write_limit(15'd16384);
    run_phase(100, 1'b0);
    write_limit(15'h7fff);
    run_phase(50, 1'b0);
    write_limit(15'd8000);
    run_phase(200, 1'b0);
    write_limit(15'(LIMIT_RST));
    run_phase(250, 1'b0);
    repeat (DRAIN) @(posedge clk_i);
    if (failures == 0) $display("rotation_matrix_to_quaternion_test passed");
    else $display("rotation_matrix_to_quaternion_test failed");
    $finish;
  end

endmodule

// File: rotation_matrix_to_quaternion.f
rtl/rmq_pkg.sv
rtl/rmq_isqrt.sv
rtl/rmq_div.sv
rtl/rotation_matrix_to_quaternion.sv
rtl/rmq_checker.sv
verif/rotation_matrix_to_quaternion_test.sv
